@@ rtl/fsd_pkg.sv @@
package fsd_pkg;

  // coordinate and normal widths
  localparam int CW   = 16;
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int NW   = PW + 1;
  localparam int MW   = PW;
  localparam int NORM = 14;
  localparam int SW   = NORM + 1;
  localparam int KW   = $clog2(MW - NORM + 2);

  // dot products, squares and the sine term
  localparam int DW        = 32;
  localparam int QW        = 30;
  localparam int PRW       = 2 * QW;
  localparam int ISQ_STEPS = PRW / 2;
  localparam int RW        = ISQ_STEPS;

  // angle unit
  localparam int CORDIC_STEPS = 28;
  localparam int XW           = 34;
  localparam int ZW           = 35;
  localparam int FFB          = 16;
  localparam int FW           = FFB + 1;
  localparam int BW           = 10;
  localparam int CHW          = 8;
  localparam int CFW          = CHW + FW;
  localparam int COLW         = 3 * CHW;

  localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'sd2147483648);
  localparam logic signed [ZW-1:0] Z_FULL = ZW'(64'sd4294967296);

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    ZW'(64'sd1073741824), ZW'(64'sd633866811), ZW'(64'sd334917815),
    ZW'(64'sd170009511), ZW'(64'sd85334662), ZW'(64'sd42708931),
    ZW'(64'sd21359677), ZW'(64'sd10680490), ZW'(64'sd5340327),
    ZW'(64'sd2670173), ZW'(64'sd1335088), ZW'(64'sd667544),
    ZW'(64'sd333772), ZW'(64'sd166886), ZW'(64'sd83443),
    ZW'(64'sd41722), ZW'(64'sd20861), ZW'(64'sd10430),
    ZW'(64'sd5215), ZW'(64'sd2608), ZW'(64'sd1304),
    ZW'(64'sd652), ZW'(64'sd326), ZW'(64'sd163),
    ZW'(64'sd81), ZW'(64'sd41), ZW'(64'sd20), ZW'(64'sd10)
  };

  // pipeline layout
  localparam int FRONT   = 10;
  localparam int FL_LOAD = 3;
  localparam int F_STAGE = FRONT + ISQ_STEPS + CORDIC_STEPS;
  localparam int FL_LEN  = F_STAGE - FL_LOAD;
  localparam int LAT     = F_STAGE + 3;
  localparam int SB_LEN  = LAT - 1;
  localparam int SBW     = COLW + CW;

  // register map
  localparam int AW = 4;
  localparam logic [1:0] REG_LIGHT_X      = 2'd0;
  localparam logic [1:0] REG_LIGHT_Y      = 2'd1;
  localparam logic [1:0] REG_LIGHT_Z      = 2'd2;
  localparam logic [1:0] REG_BRIGHTNESS   = 2'd3;

  // right shift that brings a magnitude below 2^NORM
  function automatic logic [KW-1:0] norm_k(input logic [MW-1:0] m);
    logic [KW-1:0] k;
    k = '0;
    for (int i = NORM; i < MW; i++) begin
      if (m[i]) k = KW'(i - NORM + 1);
    end
    return k;
  endfunction

  function automatic logic signed [SW-1:0] shrink1(input logic neg,
                                                   input logic [MW-1:0] m,
                                                   input logic [KW-1:0] k);
    logic [MW-1:0] t;
    logic signed [SW-1:0] q;
    t = m >> k;
    q = $signed({1'b0, t[NORM-1:0]});
    return neg ? -q : q;
  endfunction

endpackage

@@ rtl/fsd_isqrt.sv @@
module fsd_isqrt import fsd_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [PRW-1:0]        a_i,
  input  logic signed [DW-1:0]  d_i,
  output logic [RW-1:0]         s_o,
  output logic signed [DW-1:0]  d_o
);

  logic [PRW-1:0]       a_r [ISQ_STEPS];
  logic [PRW:0]         r_r [ISQ_STEPS];
  logic signed [DW-1:0] d_r [ISQ_STEPS];

  // one result bit per stage, highest first
  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_step
    localparam logic [PRW:0] BIT = (PRW+1)'(1) << (2 * (ISQ_STEPS - 1 - j));
    logic [PRW-1:0]       a_in, a_nxt;
    logic [PRW:0]         r_in, r_nxt, tr;
    logic signed [DW-1:0] d_in;

    if (j == 0) begin : g_first
      assign a_in = a_i;
      assign r_in = '0;
      assign d_in = d_i;
    end else begin : g_next
      assign a_in = a_r[j-1];
      assign r_in = r_r[j-1];
      assign d_in = d_r[j-1];
    end

    always_comb begin
      tr = r_in + BIT;
      if ({1'b0, a_in} >= tr) begin
        a_nxt = a_in - tr[PRW-1:0];
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        a_nxt = a_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[j] <= a_nxt;
        r_r[j] <= r_nxt;
        d_r[j] <= d_in;
      end
    end
  end

  assign s_o = r_r[ISQ_STEPS-1][RW-1:0];
  assign d_o = d_r[ISQ_STEPS-1];

endmodule

@@ rtl/fsd_cordic.sv @@
module fsd_cordic import fsd_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [DW-1:0]  c_i,
  input  logic [RW-1:0]         s_i,
  output logic signed [ZW-1:0]  z_o
);

  logic signed [XW-1:0] x_r [CORDIC_STEPS];
  logic signed [XW-1:0] y_r [CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] x_in, y_in, dx, dy, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_in, z_nxt;

    if (i == 0) begin : g_first
      logic signed [XW-1:0] c_x, s_x;
      assign c_x = XW'(c_i);
      assign s_x = $signed({{(XW-RW){1'b0}}, s_i});
      // rotate by -90 degrees when the cosine is negative
      assign x_in = c_i[DW-1] ? s_x : c_x;
      assign y_in = c_i[DW-1] ? -c_x : s_x;
      assign z_in = c_i[DW-1] ? Z_HALF : '0;
    end else begin : g_next
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
    end

    always_comb begin
      dx = x_in >>> i;
      dy = y_in >>> i;
      if (!y_in[XW-1]) begin
        x_nxt = x_in + dy;
        y_nxt = y_in - dx;
        z_nxt = z_in + ATAN_TAB[i];
      end else begin
        x_nxt = x_in - dy;
        y_nxt = y_in + dx;
        z_nxt = z_in - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  assign z_o = z_r[CORDIC_STEPS-1];

endmodule

@@ rtl/triangle_flat_shading_top.sv @@
// Throughput: one triangle per cycle; the 30-stage square root and the
// 28-stage angle unit are fully pipelined and stall as one with the output.
// Reset (synchronous, rst_n low) clears all valid bits and loads the light
// vector to (0,0,1) and brightness to 256.
module triangle_flat_shading_top import fsd_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
  // vertex_c_x, vertex_c_y, vertex_c_z, base_color
  input  logic [167:0]    in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // shaded_red, shaded_green, shaded_blue, nearest_depth
  output logic [39:0]     out_tdata,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [AW-1:0]   cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  logic adv;
  logic v_r [LAT];
  logic [SBW-1:0] sb_r [SB_LEN];
  logic fl_r [FL_LEN];

  // ---------------- configuration
  logic signed [CW-1:0] lx_r, ly_r, lz_r;
  logic [BW-1:0] bright_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r     <= '0;
      ly_r     <= '0;
      lz_r     <= CW'(1);
      bright_r <= BW'(256);
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_LIGHT_X:    lx_r     <= cfg_pwdata[CW-1:0];
        REG_LIGHT_Y:    ly_r     <= cfg_pwdata[CW-1:0];
        REG_LIGHT_Z:    lz_r     <= cfg_pwdata[CW-1:0];
        REG_BRIGHTNESS: bright_r <= cfg_pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_LIGHT_X:    cfg_prdata = 32'({lx_r});
      REG_LIGHT_Y:    cfg_prdata = 32'({ly_r});
      REG_LIGHT_Z:    cfg_prdata = 32'({lz_r});
      REG_BRIGHTNESS: cfg_prdata = 32'(bright_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // shrunk light vector and its squared length, refreshed every cycle
  logic signed [SW-1:0] lsh_r [3];
  logic [QW-1:0] ll_r;
  logic lnz_r;
  logic [MW-1:0] lmag [3];
  logic [MW-1:0] lmax;
  logic [KW-1:0] lk;
  logic signed [2*SW-1:0] lsq [3];

  always_comb begin
    lmag[0] = MW'(lx_r[CW-1] ? -EW'(lx_r) : EW'(lx_r));
    lmag[1] = MW'(ly_r[CW-1] ? -EW'(ly_r) : EW'(ly_r));
    lmag[2] = MW'(lz_r[CW-1] ? -EW'(lz_r) : EW'(lz_r));
    lmax = lmag[0];
    if (lmag[1] > lmax) lmax = lmag[1];
    if (lmag[2] > lmax) lmax = lmag[2];
    lk = norm_k(lmax);
    for (int i = 0; i < 3; i++) lsq[i] = lsh_r[i] * lsh_r[i];
  end

  always_ff @(posedge clk) begin
    lsh_r[0] <= shrink1(lx_r[CW-1], lmag[0], lk);
    lsh_r[1] <= shrink1(ly_r[CW-1], lmag[1], lk);
    lsh_r[2] <= shrink1(lz_r[CW-1], lmag[2], lk);
    lnz_r    <= |{lx_r, ly_r, lz_r};
    ll_r     <= $unsigned(lsq[0]) + $unsigned(lsq[1]) + $unsigned(lsq[2]);
  end

  // ---------------- pipeline control
  assign out_tvalid = v_r[LAT-1];
  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_tvalid;
      for (int i = 1; i < LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  // ---------------- stage 0: edges and depth
  logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  logic signed [CW-1:0] zmin;
  logic signed [EW-1:0] e_r [6];

  always_comb begin
    ax = in_tdata[15:0];    ay = in_tdata[31:16];   az = in_tdata[47:32];
    bx = in_tdata[63:48];   by = in_tdata[79:64];   bz = in_tdata[95:80];
    cx = in_tdata[111:96];  cy = in_tdata[127:112]; cz = in_tdata[143:128];
    zmin = (az < bz) ? az : bz;
    if (cz < zmin) zmin = cz;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r[0] <= EW'(ax) - EW'(bx);
      e_r[1] <= EW'(ay) - EW'(by);
      e_r[2] <= EW'(az) - EW'(bz);
      e_r[3] <= EW'(bx) - EW'(cx);
      e_r[4] <= EW'(by) - EW'(cy);
      e_r[5] <= EW'(bz) - EW'(cz);
      sb_r[0] <= {in_tdata[167:144], zmin};
      for (int i = 1; i < SB_LEN; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  // ---------------- stage 1: cross product terms
  logic signed [PW-1:0] pr_r [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      pr_r[0] <= PW'(e_r[1]) * PW'(e_r[5]);
      pr_r[1] <= PW'(e_r[2]) * PW'(e_r[4]);
      pr_r[2] <= PW'(e_r[2]) * PW'(e_r[3]);
      pr_r[3] <= PW'(e_r[0]) * PW'(e_r[5]);
      pr_r[4] <= PW'(e_r[0]) * PW'(e_r[4]);
      pr_r[5] <= PW'(e_r[1]) * PW'(e_r[3]);
    end
  end

  // ---------------- stage 2: normal
  logic signed [NW-1:0] n_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) n_r[i] <= NW'(pr_r[2*i]) - NW'(pr_r[2*i+1]);
    end
  end

  // ---------------- stage 3: magnitudes and largest
  logic [MW-1:0] mag_r [3];
  logic [MW-1:0] mx_r;
  logic sg_r [3];
  logic [MW-1:0] nmag [3];
  logic [MW-1:0] nmax;

  always_comb begin
    for (int i = 0; i < 3; i++) nmag[i] = MW'(n_r[i][NW-1] ? -n_r[i] : n_r[i]);
    nmax = nmag[0];
    if (nmag[1] > nmax) nmax = nmag[1];
    if (nmag[2] > nmax) nmax = nmag[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= nmag[i];
        sg_r[i]  <= n_r[i][NW-1];
      end
      mx_r <= nmax;
      fl_r[0] <= |{n_r[0], n_r[1], n_r[2]};
      for (int i = 1; i < FL_LEN; i++) fl_r[i] <= fl_r[i-1];
    end
  end

  // ---------------- stage 4: shift amount
  logic [KW-1:0] k_r;
  logic [MW-1:0] mag4_r [3];
  logic sg4_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      k_r <= norm_k(mx_r);
      for (int i = 0; i < 3; i++) begin
        mag4_r[i] <= mag_r[i];
        sg4_r[i]  <= sg_r[i];
      end
    end
  end

  // ---------------- stage 5: shrunk normal
  logic signed [SW-1:0] ns_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) ns_r[i] <= shrink1(sg4_r[i], mag4_r[i], k_r);
    end
  end

  // ---------------- stage 6: dot and square terms
  logic signed [2*SW-1:0] dp_r [3];
  logic signed [2*SW-1:0] sq_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dp_r[i] <= ns_r[i] * lsh_r[i];
        sq_r[i] <= ns_r[i] * ns_r[i];
      end
    end
  end

  // ---------------- stage 7: sums
  logic signed [DW-1:0] d_r;
  logic [QW-1:0] nn_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r  <= DW'(dp_r[0]) + DW'(dp_r[1]) + DW'(dp_r[2]);
      nn_r <= $unsigned(sq_r[0]) + $unsigned(sq_r[1]) + $unsigned(sq_r[2]);
    end
  end

  // ---------------- stage 8: squared lengths product and squared dot
  logic [PRW-1:0] p_r, d2_r;
  logic signed [DW-1:0] d8_r;
  logic signed [2*DW-1:0] dsq;

  assign dsq = d_r * d_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r  <= PRW'(nn_r) * PRW'(ll_r);
      d2_r <= dsq[PRW-1:0];
      d8_r <= d_r;
    end
  end

  // ---------------- stage 9: radicand
  logic [PRW-1:0] a_r;
  logic signed [DW-1:0] d9_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r  <= (p_r >= d2_r) ? p_r - d2_r : '0;
      d9_r <= d8_r;
    end
  end

  // ---------------- square root and angle
  logic [RW-1:0] s_w;
  logic signed [DW-1:0] dq_w;
  logic signed [ZW-1:0] z_w;

  fsd_isqrt u_isqrt (
    .clk (clk),
    .en  (adv),
    .a_i (a_r),
    .d_i (d9_r),
    .s_o (s_w),
    .d_o (dq_w)
  );

  fsd_cordic u_cordic (
    .clk (clk),
    .en  (adv),
    .c_i (dq_w),
    .s_i (s_w),
    .z_o (z_w)
  );

  // ---------------- factor: clamp angle, drop to FFB fraction bits
  logic [FW-1:0] f_r;
  logic signed [ZW-1:0] zc;

  always_comb begin
    if (z_w[ZW-1])       zc = '0;
    else if (z_w > Z_FULL) zc = Z_FULL;
    else                 zc = z_w;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r <= (fl_r[FL_LEN-1] && lnz_r) ? zc[32-FFB +: FW] : '0;
    end
  end

  // ---------------- shade: channel times factor, then brightness
  logic [CFW-1:0] cf_r [3];
  logic [SBW-1:0] sb_f;

  assign sb_f = sb_r[F_STAGE];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        cf_r[i] <= CFW'(sb_f[CW + CHW*i +: CHW]) * CFW'(f_r);
      end
    end
  end

  logic [CFW+BW-1:0] sv [3];
  logic [CHW-1:0] ch_sat [3];
  logic [CHW-1:0] ch_r [3];
  logic [CW-1:0] depth_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = (CFW+BW)'(cf_r[i]) * (CFW+BW)'(bright_r);
      ch_sat[i] = (|sv[i][CFW+BW-1:FFB+8+CHW]) ? '1 : sv[i][FFB+8 +: CHW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) ch_r[i] <= ch_sat[i];
      depth_r <= sb_r[SB_LEN-1][CW-1:0];
    end
  end

  // channel i holds blue, green, red from the bottom of the color
  assign out_tdata = {depth_r, ch_r[0], ch_r[1], ch_r[2]};

endmodule

@@ tb/tb_triangle_flat_shading_top.sv @@
module tb_triangle_flat_shading_top;
  import fsd_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = LAT + 10;

  typedef struct {
    logic signed [15:0] v[9];   // ax ay az bx by bz cx cy cz
    logic [23:0]        color;
  } tri_t;

  typedef struct packed {
    logic signed [15:0] depth;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } shade_t;

  typedef struct {
    logic [167:0] data;
    bit           typed;
    shade_t       want;
  } row_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [39:0]  out_tdata;
  logic         cfg_psel = 0;
  logic         cfg_penable = 0;
  logic         cfg_pwrite = 0;
  logic [AW-1:0] cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  logic signed [15:0] light_vec[3];
  logic [9:0]         bright_lvl;
  shade_t             shade_q[$];
  int                 err_cnt = 0;
  int                 cycle_cnt = 0;
  bit                 no_idle = 0;

  triangle_flat_shading_top u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [167:0] pack_tri(tri_t t);
    logic [167:0] d;
    for (int i = 0; i < 9; i++) d[16*i +: 16] = t.v[i];
    d[144 +: 24] = t.color;
    return d;
  endfunction

  function automatic tri_t unpack_tri(logic [167:0] d);
    tri_t t;
    for (int i = 0; i < 9; i++) t.v[i] = d[16*i +: 16];
    t.color = d[144 +: 24];
    return t;
  endfunction

  function automatic logic [167:0] mk(int ax, int ay, int az, int bx, int by, int bz,
                                     int cx, int cy, int cz, logic [23:0] col);
    tri_t t;
    t.v[0] = 16'(ax); t.v[1] = 16'(ay); t.v[2] = 16'(az);
    t.v[3] = 16'(bx); t.v[4] = 16'(by); t.v[5] = 16'(bz);
    t.v[6] = 16'(cx); t.v[7] = 16'(cy); t.v[8] = 16'(cz);
    t.color = col;
    return pack_tri(t);
  endfunction

  // scale a vector down until every component fits in NORM bits, sign kept
  function automatic void narrow_vec(inout longint w[3]);
    longint unsigned mag[3];
    longint unsigned m;
    int k;
    m = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = w[i] < 0 ? -w[i] : w[i];
      if (mag[i] > m) m = mag[i];
    end
    while ((m >> k) >= (64'd1 << NORM)) k++;
    for (int i = 0; i < 3; i++) w[i] = w[i] < 0 ? -longint'(mag[i] >> k) : longint'(mag[i] >> k);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // normal-to-light angle in units of pi / 2^32
  function automatic longint light_angle(longint c, longint s);
    longint x, y, z, dx, dy;
    if (c < 0) begin
      x = s; y = -c; z = 64'sd1 << 31;
    end else begin
      x = c; y = s; z = 0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dy; y += dx; z -= longint'(ATAN_TAB[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 << 32)) z = 64'sd1 << 32;
    return z;
  endfunction

  function automatic logic [7:0] scale_chan(longint unsigned ch, longint unsigned f);
    longint unsigned v;
    v = (ch * f * bright_lvl) >> (FFB + 8);
    return v > 255 ? 8'hff : v[7:0];
  endfunction

  function automatic shade_t shade_tri(tri_t t);
    longint e1[3], e2[3], n[3], l[3];
    longint d, nn, ll;
    longint unsigned p, d2, f;
    shade_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(t.v[i]) - longint'(t.v[3+i]);
      e2[i] = longint'(t.v[3+i]) - longint'(t.v[6+i]);
      l[i]  = light_vec[i];
    end
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    f = 0;
    if ((n[0] | n[1] | n[2]) != 0 && (l[0] | l[1] | l[2]) != 0) begin
      narrow_vec(n);
      narrow_vec(l);
      d  = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
      nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
      ll = l[0] * l[0] + l[1] * l[1] + l[2] * l[2];
      p  = nn * ll;
      d2 = d < 0 ? -d : d;
      d2 = d2 * d2;
      f  = longint'(light_angle(d, int_sqrt(p >= d2 ? p - d2 : 0))) >> (32 - FFB);
    end
    r.red   = scale_chan(t.color[23:16], f);
    r.green = scale_chan(t.color[15:8], f);
    r.blue  = scale_chan(t.color[7:0], f);
    r.depth = t.v[2];
    if (t.v[5] < r.depth) r.depth = t.v[5];
    if (t.v[8] < r.depth) r.depth = t.v[8];
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1; cfg_pwrite = 1; cfg_penable = 0;
    cfg_paddr = AW'({idx, 2'b00});
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_LIGHT_X:    light_vec[0] = val[15:0];
      REG_LIGHT_Y:    light_vec[1] = val[15:0];
      REG_LIGHT_Z:    light_vec[2] = val[15:0];
      REG_BRIGHTNESS: bright_lvl = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0;
  endtask

  task automatic set_light(int x, int y, int z, int b);
    write_reg(REG_LIGHT_X, x);
    write_reg(REG_LIGHT_Y, y);
    write_reg(REG_LIGHT_Z, z);
    write_reg(REG_BRIGHTNESS, b);
  endtask

  task automatic send_beat(logic [167:0] d, bit typed, shade_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 0;
    end
    @(negedge clk);
    in_tvalid = 1;
    in_tdata = d;
    do @(posedge clk); while (!in_tready);
    shade_q.push_back(typed ? want : shade_tri(unpack_tri(d)));
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid = 0;
    while (shade_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic tri_t rand_tri();
    tri_t t;
    int base[3];
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) base[i] = $urandom_range(0, 60000) - 30000;
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0: t.v[i] = 16'($urandom);
        1: t.v[i] = 16'(base[i % 3] + int'($urandom_range(0, 600)) - 300);
        2: t.v[i] = 16'(base[i % 3] + int'($urandom_range(0, 16)) - 8);
        default: t.v[i] = 0;
      endcase
    end
    // collinear: C continues the line from A through B
    if (mode == 3) begin
      for (int i = 0; i < 3; i++) begin
        t.v[i]   = 16'(base[i] % 1000);
        t.v[3+i] = 16'(int'(t.v[i]) + int'($urandom_range(0, 200)) - 100);
        t.v[6+i] = 16'(2 * int'(t.v[3+i]) - int'(t.v[i]));
      end
    end
    t.color = 24'($urandom);
    return t;
  endfunction

  always @(posedge clk) begin
    shade_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (shade_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected beat: %h", got);
      end else begin
        want = shade_q.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.depth !== want.depth) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp r=%0d g=%0d b=%0d z=%0d, got r=%0d g=%0d b=%0d z=%0d",
                     want.red, want.green, want.blue, want.depth,
                     got.red, got.green, got.blue, got.depth);
        end
      end
    end
  end

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
        @(negedge clk);
        out_tready = 0;
      end
      @(negedge clk);
      out_tready = 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    row_t dir_tab[$];
    shade_t none;
    int lights[6][4];
    none = '0;
    light_vec[0] = 0; light_vec[1] = 0; light_vec[2] = 1;
    bright_lvl = 256;
    dir_tab = '{
      // degenerate triangles give black
      '{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'hffffff), 1, '{16'sd0, 8'd0, 8'd0, 8'd0}},
      '{mk(1, 2, 3, 2, 4, 6, 3, 6, 9, 24'hffffff), 1, '{16'sd3, 8'd0, 8'd0, 8'd0}},
      '{mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 24'hffffff),
        1, '{16'sh7fff, 8'd0, 8'd0, 8'd0}},
      '{mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
           24'h808080), 1, '{16'sh8000, 8'd0, 8'd0, 8'd0}},
      '{mk(0, 0, 0, 1, 0, 0, 1, 1, 0, 24'hffffff), 0, none},
      '{mk(0, 0, 0, 1, 1, 0, 1, 0, 0, 24'hffffff), 0, none},
      '{mk(0, 0, 0, 1, 1, 0, 1, 0, 0, 24'h000000), 0, none},
      '{mk(0, 0, 0, 1, 1, 0, 1, 0, 0, 24'hff0000), 0, none},
      '{mk(0, 0, 0, 1, 1, 0, 1, 0, 0, 24'h00ff00), 0, none},
      '{mk(0, 0, 0, 1, 1, 0, 1, 0, 0, 24'h0000ff), 0, none},
      '{mk(0, 0, 0, 0, 1, 0, 0, 0, 1, 24'h123456), 0, none},
      '{mk(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767,
           24'hffffff), 0, none},
      '{mk(32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768,
           24'ha5a5a5), 0, none},
      '{mk(-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768, 24'h5a5a5a), 0, none},
      '{mk(100, 200, -5, -300, 40, 7, 60, -90, 3, 24'hfedcba), 0, none},
      '{mk(0, 0, 10, 5, 0, 10, 0, 5, 11, 24'h804020), 0, none}
    };
    lights = '{
      '{-20000, 12000, -30000, 400},
      '{0, 0, 0, 256},
      '{32767, -32768, 32767, 1023},
      '{-32768, 32767, -32768, 0},
      '{1, -1, 1, 512},
      '{12345, -321, 7, 300}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (dir_tab[i]) send_beat(dir_tab[i].data, dir_tab[i].typed, dir_tab[i].want);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_light(lights[ph][0], lights[ph][1], lights[ph][2], lights[ph][3]);
      no_idle = (ph == 2);
      foreach (dir_tab[i]) if (i >= 4) send_beat(dir_tab[i].data, 0, none);
      repeat (130) send_beat(pack_tri(rand_tri()), 0, none);
      drain();
    end

    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
